[design/qefa_pkg.sv]
// Shared types, constants and microcode for the quadratic extension field ALU.
package qefa_pkg;

  localparam int FW    = 62;  // base field residue width
  localparam int EW    = 64;  // exponent and Barrett reciprocal width
  localparam int RF_AW = 4;
  localparam int PC_W  = 7;
  localparam logic [PC_W-1:0] UCODE_LEN = 7'd82;

  // configuration register indexes
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_BITS    = 2'd1;
  localparam logic [1:0] CFG_RECIP   = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_NEG  = 3'd3,
    OP_MULW = 3'd4,
    OP_INV  = 3'd5,
    OP_POW  = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    U_NOP, U_MODIN, U_CONST0, U_CONST1, U_DISPATCH, U_ADD, U_SUB, U_MUL,
    U_ELOADI, U_ELOADP, U_ESHIFT, U_BRZ, U_BRL0, U_JMP, U_DONE
  } uop_e;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT} ctl_state_e;

  typedef enum logic [2:0] {BAR_IDLE, BAR_M1, BAR_M2, BAR_M3, BAR_M4} bar_ph_e;

  typedef struct packed {
    logic [2:0]    operation;
    logic [FW-1:0] a_re;
    logic [FW-1:0] a_im;
    logic [FW-1:0] b_re;
    logic [FW-1:0] b_im;
    logic [EW-1:0] exponent;
  } in_item_t;

  typedef struct packed {
    logic [FW-1:0] r_re;
    logic [FW-1:0] r_im;
  } out_item_t;

  typedef struct packed {
    uop_e             uop;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] src_a;
    logic [RF_AW-1:0] src_b;
    logic [PC_W-1:0]  target;
  } uinstr_t;

  typedef struct packed {
    logic             capture;
    logic             exec;
    uop_e             uop;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] ra;
    logic [RF_AW-1:0] rb;
  } ctl_cmd_t;

  typedef struct packed {
    logic       unit_done;
    logic       e_zero;
    logic       e_lsb;
    logic       out_free;
    logic       mod_zero;
    logic [2:0] op;
  } dp_status_t;

  // register file slots
  localparam logic [RF_AW-1:0] R_ARE  = 4'd0;
  localparam logic [RF_AW-1:0] R_AIM  = 4'd1;
  localparam logic [RF_AW-1:0] R_BRE  = 4'd2;
  localparam logic [RF_AW-1:0] R_BIM  = 4'd3;
  localparam logic [RF_AW-1:0] R_ZERO = 4'd4;
  localparam logic [RF_AW-1:0] R_RE   = 4'd5;
  localparam logic [RF_AW-1:0] R_IM   = 4'd6;
  localparam logic [RF_AW-1:0] R_T0   = 4'd7;
  localparam logic [RF_AW-1:0] R_T1   = 4'd8;
  localparam logic [RF_AW-1:0] R_T2   = 4'd9;
  localparam logic [RF_AW-1:0] R_T3   = 4'd10;
  localparam logic [RF_AW-1:0] R_T4   = 4'd11;
  localparam logic [RF_AW-1:0] R_NRM  = 4'd13;
  localparam logic [RF_AW-1:0] R_IACC = 4'd14;
  localparam logic [RF_AW-1:0] R_ONE  = 4'd15;

  // program entry points
  localparam logic [PC_W-1:0] A_PRO      = 7'd0;
  localparam logic [PC_W-1:0] A_ADD      = 7'd7;
  localparam logic [PC_W-1:0] A_SUB      = 7'd10;
  localparam logic [PC_W-1:0] A_NEG      = 7'd13;
  localparam logic [PC_W-1:0] A_MULW     = 7'd16;
  localparam logic [PC_W-1:0] A_ZERO     = 7'd25;
  localparam logic [PC_W-1:0] A_MUL      = 7'd26;
  localparam logic [PC_W-1:0] A_INV      = 7'd37;
  localparam logic [PC_W-1:0] A_INV_LOOP = 7'd44;
  localparam logic [PC_W-1:0] A_INV_SQR  = 7'd47;
  localparam logic [PC_W-1:0] A_INV_END  = 7'd50;
  localparam logic [PC_W-1:0] A_POW      = 7'd54;
  localparam logic [PC_W-1:0] A_POW_LOOP = 7'd57;
  localparam logic [PC_W-1:0] A_POW_MUL  = 7'd59;
  localparam logic [PC_W-1:0] A_POW_SQR  = 7'd69;
  localparam logic [PC_W-1:0] A_POW_END  = 7'd81;
  localparam logic [PC_W-1:0] EXT_LEN    = 7'd10;

  function automatic uinstr_t mk(input uop_e u, input logic [RF_AW-1:0] d,
                                 input logic [RF_AW-1:0] a, input logic [RF_AW-1:0] b);
    uinstr_t r;
    r.uop = u;
    r.dst = d;
    r.src_a = a;
    r.src_b = b;
    r.target = A_PRO;
    return r;
  endfunction

  function automatic uinstr_t mkj(input uop_e u, input logic [PC_W-1:0] t);
    uinstr_t r;
    r = mk(u, R_ZERO, R_ZERO, R_ZERO);
    r.target = t;
    return r;
  endfunction

  // Karatsuba extension product (x) * (y) -> (d), i^2 = -3
  function automatic uinstr_t ext_step(input logic [3:0] k,
      input logic [RF_AW-1:0] xr, input logic [RF_AW-1:0] xi,
      input logic [RF_AW-1:0] yr, input logic [RF_AW-1:0] yi,
      input logic [RF_AW-1:0] dr, input logic [RF_AW-1:0] di);
    uinstr_t r;
    case (k)
      4'd0:    r = mk(U_ADD, R_T0, xr, xi);
      4'd1:    r = mk(U_ADD, R_T1, yr, yi);
      4'd2:    r = mk(U_MUL, R_T2, R_T0, R_T1);
      4'd3:    r = mk(U_MUL, R_T3, xr, yr);
      4'd4:    r = mk(U_MUL, R_T4, xi, yi);
      4'd5:    r = mk(U_ADD, R_T0, R_T4, R_T4);
      4'd6:    r = mk(U_ADD, R_T0, R_T0, R_T4);
      4'd7:    r = mk(U_SUB, R_T2, R_T2, R_T3);
      4'd8:    r = mk(U_SUB, dr, R_T3, R_T0);
      default: r = mk(U_SUB, di, R_T2, R_T4);
    endcase
    return r;
  endfunction

  function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
    uinstr_t r;
    logic [PC_W-1:0] off;
    case (pc)
      // prologue: reduce operands, load constants
      7'd0:  r = mk(U_MODIN, R_ARE, R_ARE, R_ZERO);
      7'd1:  r = mk(U_MODIN, R_AIM, R_AIM, R_ZERO);
      7'd2:  r = mk(U_MODIN, R_BRE, R_BRE, R_ZERO);
      7'd3:  r = mk(U_MODIN, R_BIM, R_BIM, R_ZERO);
      7'd4:  r = mk(U_CONST0, R_ZERO, R_ZERO, R_ZERO);
      7'd5:  r = mk(U_CONST1, R_ONE, R_ZERO, R_ZERO);
      7'd6:  r = mk(U_DISPATCH, R_ZERO, R_ZERO, R_ZERO);
      7'd7:  r = mk(U_ADD, R_RE, R_ARE, R_BRE);
      7'd8:  r = mk(U_ADD, R_IM, R_AIM, R_BIM);
      7'd9:  r = mk(U_DONE, R_ZERO, R_RE, R_IM);
      7'd10: r = mk(U_SUB, R_RE, R_ARE, R_BRE);
      7'd11: r = mk(U_SUB, R_IM, R_AIM, R_BIM);
      7'd12: r = mk(U_DONE, R_ZERO, R_RE, R_IM);
      7'd13: r = mk(U_SUB, R_RE, R_ZERO, R_ARE);
      7'd14: r = mk(U_SUB, R_IM, R_ZERO, R_AIM);
      7'd15: r = mk(U_DONE, R_ZERO, R_RE, R_IM);
      // multiply by (-3 + i)
      7'd16: r = mk(U_ADD, R_T0, R_ARE, R_AIM);
      7'd17: r = mk(U_SUB, R_T0, R_ZERO, R_T0);
      7'd18: r = mk(U_ADD, R_T1, R_T0, R_T0);
      7'd19: r = mk(U_ADD, R_RE, R_T1, R_T0);
      7'd20: r = mk(U_SUB, R_T2, R_ZERO, R_AIM);
      7'd21: r = mk(U_ADD, R_T3, R_T2, R_T2);
      7'd22: r = mk(U_ADD, R_T3, R_T3, R_T2);
      7'd23: r = mk(U_ADD, R_IM, R_ARE, R_T3);
      7'd24: r = mk(U_DONE, R_ZERO, R_RE, R_IM);
      7'd25: r = mk(U_DONE, R_ZERO, R_ZERO, R_ZERO);
      7'd36: r = mk(U_DONE, R_ZERO, R_RE, R_IM);
      // inverse: conjugate times norm^(p-2)
      7'd37: r = mk(U_MUL, R_T0, R_AIM, R_AIM);
      7'd38: r = mk(U_ADD, R_T1, R_T0, R_T0);
      7'd39: r = mk(U_ADD, R_T1, R_T1, R_T0);
      7'd40: r = mk(U_MUL, R_T2, R_ARE, R_ARE);
      7'd41: r = mk(U_ADD, R_NRM, R_T2, R_T1);
      7'd42: r = mk(U_ADD, R_IACC, R_ONE, R_ZERO);
      7'd43: r = mk(U_ELOADP, R_ZERO, R_ZERO, R_ZERO);
      7'd44: r = mkj(U_BRZ, A_INV_END);
      7'd45: r = mkj(U_BRL0, A_INV_SQR);
      7'd46: r = mk(U_MUL, R_IACC, R_IACC, R_NRM);
      7'd47: r = mk(U_MUL, R_NRM, R_NRM, R_NRM);
      7'd48: r = mk(U_ESHIFT, R_ZERO, R_ZERO, R_ZERO);
      7'd49: r = mkj(U_JMP, A_INV_LOOP);
      7'd50: r = mk(U_MUL, R_RE, R_ARE, R_IACC);
      7'd51: r = mk(U_MUL, R_T0, R_AIM, R_IACC);
      7'd52: r = mk(U_SUB, R_IM, R_ZERO, R_T0);
      7'd53: r = mk(U_DONE, R_ZERO, R_RE, R_IM);
      // power, exponent LSB first
      7'd54: r = mk(U_ADD, R_RE, R_ONE, R_ZERO);
      7'd55: r = mk(U_ADD, R_IM, R_ZERO, R_ZERO);
      7'd56: r = mk(U_ELOADI, R_ZERO, R_ZERO, R_ZERO);
      7'd57: r = mkj(U_BRZ, A_POW_END);
      7'd58: r = mkj(U_BRL0, A_POW_SQR);
      7'd79: r = mk(U_ESHIFT, R_ZERO, R_ZERO, R_ZERO);
      7'd80: r = mkj(U_JMP, A_POW_LOOP);
      7'd81: r = mk(U_DONE, R_ZERO, R_RE, R_IM);
      default: r = mk(U_NOP, R_ZERO, R_ZERO, R_ZERO);
    endcase
    if (pc >= A_MUL && pc < A_MUL + EXT_LEN) begin
      off = pc - A_MUL;
      r = ext_step(off[3:0], R_ARE, R_AIM, R_BRE, R_BIM, R_RE, R_IM);
    end
    if (pc >= A_POW_MUL && pc < A_POW_MUL + EXT_LEN) begin
      off = pc - A_POW_MUL;
      r = ext_step(off[3:0], R_RE, R_IM, R_ARE, R_AIM, R_RE, R_IM);
    end
    if (pc >= A_POW_SQR && pc < A_POW_SQR + EXT_LEN) begin
      off = pc - A_POW_SQR;
      r = ext_step(off[3:0], R_ARE, R_AIM, R_ARE, R_AIM, R_ARE, R_AIM);
    end
    return r;
  endfunction

  function automatic logic [PC_W-1:0] entry(input logic [2:0] op, input logic mod_zero);
    logic [PC_W-1:0] a;
    case (op)
      OP_ADD:  a = A_ADD;
      OP_SUB:  a = A_SUB;
      OP_MUL:  a = A_MUL;
      OP_NEG:  a = A_NEG;
      OP_MULW: a = A_MULW;
      OP_INV:  a = A_INV;
      OP_POW:  a = A_POW;
      default: a = A_ZERO;
    endcase
    if (mod_zero) a = A_ZERO;
    return a;
  endfunction

endpackage

[design/quadratic_extension_field_alu_core.sv]
// Arithmetic unit for F_p[i], i^2 = -3: add, sub, Karatsuba multiply, negate, multiply by
// (-3 + i), inverse (conjugate times norm^(p-2), zero maps to zero) and power over a 64-bit
// exponent. Products use Barrett reduction driven by the modulus, bit length and reciprocal
// registers; every result is reduced below p, and a zero modulus or operation code seven
// gives zero. One item is processed at a time by a microcoded sequencer over one register
// file, one 4-pass 32x32 multiplier and one bit-serial remainder unit. A base field
// product takes four 64x64 products plus a 64-step remainder, and every item starts
// with operand reduction; inverse and power repeat products for each bit of p-2 or of
// the exponent. The next item is accepted while a finished result waits.
module quadratic_extension_field_alu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qefa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qefa_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i
);

  qefa_pkg::ctl_cmd_t   cmd;
  qefa_pkg::dp_status_t status;

  qefa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  qefa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

[design/qefa_mul64.sv]
// 64x64 -> 128 multiplier built from one 32x32 multiplier, one partial product at a time.
module qefa_mul64 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [31:0]  a_half, b_half;
  logic [1:0]   sh_d;

  assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];
  assign sh_d   = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd4);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= a_half * b_half;
      sh_q <= sh_d;
      // partial product registered, accumulated in the next cycle
      if (cnt_q != 3'd0) acc_q <= acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

[design/qefa_barrett.sv]
// Barrett reduction core: product, quotient estimate and remainder before the final mod.
module qefa_barrett (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [qefa_pkg::FW-1:0] x_i,
  input  logic [qefa_pkg::FW-1:0] y_i,
  input  logic [qefa_pkg::FW-1:0] mod_i,
  input  logic [5:0]             bits_i,
  input  logic [qefa_pkg::EW-1:0] recip_i,
  output logic                   done_o,
  output logic [63:0]            res_o
);

  qefa_pkg::bar_ph_e ph_q, ph_d;
  logic [63:0]  hs_q, ls_q, r0n_q;
  logic [63:0]  hs_d, ls_d, r0n_d, r1n_d, q_d, r0m, r1m;
  logic [63:0]  mask, modw;
  logic [5:0]   len;
  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod, prod_sh;

  assign len     = (bits_i == 6'd0) ? 6'd1 : bits_i;
  assign mask    = (64'd1 << len) - 64'd1;
  assign modw    = {{(64-qefa_pkg::FW){1'b0}}, mod_i};
  assign prod_sh = prod >> len;

  always_comb begin
    ph_d      = ph_q;
    mul_start = 1'b0;
    mul_a     = {{(64-qefa_pkg::FW){1'b0}}, x_i};
    mul_b     = {{(64-qefa_pkg::FW){1'b0}}, y_i};
    done_o    = 1'b0;
    hs_d      = prod_sh[63:0];
    ls_d      = prod[63:0] & mask;
    q_d       = prod_sh[63:0];
    r0m       = prod[63:0] & mask;
    r1m       = prod_sh[63:0];
    r0n_d     = ls_q - r0m;
    r1n_d     = hs_q - r1m - {63'd0, (ls_q < r0n_d)};
    res_o     = (r0n_q - prod[63:0]) & mask;
    case (ph_q)
      qefa_pkg::BAR_IDLE: begin
        if (start_i) begin
          mul_start = 1'b1;
          ph_d      = qefa_pkg::BAR_M1;
        end
      end
      qefa_pkg::BAR_M1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = hs_d;
          mul_b     = recip_i;
          ph_d      = qefa_pkg::BAR_M2;
        end
      end
      qefa_pkg::BAR_M2: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = q_d;
          mul_b     = modw;
          ph_d      = qefa_pkg::BAR_M3;
        end
      end
      qefa_pkg::BAR_M3: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = r1n_d;
          mul_b     = modw;
          ph_d      = qefa_pkg::BAR_M4;
        end
      end
      qefa_pkg::BAR_M4: begin
        if (mul_done) begin
          done_o = 1'b1;
          ph_d   = qefa_pkg::BAR_IDLE;
        end
      end
      default: ph_d = qefa_pkg::BAR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= qefa_pkg::BAR_IDLE;
    else         ph_q <= ph_d;
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == qefa_pkg::BAR_M1 && mul_done) begin
      hs_q <= hs_d;
      ls_q <= ls_d;
    end
    if (ph_q == qefa_pkg::BAR_M3 && mul_done) r0n_q <= r0n_d;
  end

  qefa_mul64 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (prod)
  );

endmodule

[design/qefa_modu.sv]
// Restoring remainder unit: 64-bit value modulo the field modulus, one bit per cycle.
module qefa_modu (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [63:0]            val_i,
  input  logic [qefa_pkg::FW-1:0] mod_i,
  output logic                   done_o,
  output logic [qefa_pkg::FW-1:0] rem_o
);

  logic [qefa_pkg::FW-1:0] rem_q, m_q, rem_d;
  logic [63:0]             v_q;
  logic [5:0]              cnt_q;
  logic                    busy_q, done_q;
  logic [qefa_pkg::FW:0]   t, diff;

  assign t     = {rem_q, v_q[63]};
  assign diff  = t - {1'b0, m_q};
  assign rem_d = (t >= {1'b0, m_q}) ? diff[qefa_pkg::FW-1:0] : t[qefa_pkg::FW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      v_q   <= val_i;
      m_q   <= mod_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      v_q   <= {v_q[62:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[design/qefa_ctrl.sv]
// Microcode sequencer: program counter, fetch/execute state machine, branches.
module qefa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  qefa_pkg::dp_status_t status_i,
  output qefa_pkg::ctl_cmd_t   cmd_o
);

  qefa_pkg::ctl_state_e      state_q, state_d;
  logic [qefa_pkg::PC_W-1:0] pc_q, pc_d, pc_inc;
  qefa_pkg::uinstr_t         instr;

  assign instr  = qefa_pkg::ucode(pc_q);
  assign pc_inc = pc_q + qefa_pkg::PC_W'(1);

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = (state_q == qefa_pkg::ST_EXEC);
    cmd_o.uop     = instr.uop;
    cmd_o.dst     = instr.dst;
    cmd_o.ra      = instr.src_a;
    cmd_o.rb      = instr.src_b;
    case (state_q)
      qefa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          pc_d          = qefa_pkg::A_PRO;
          state_d       = qefa_pkg::ST_FETCH;
        end
      end
      qefa_pkg::ST_FETCH: state_d = qefa_pkg::ST_EXEC;
      qefa_pkg::ST_EXEC: begin
        state_d = qefa_pkg::ST_FETCH;
        pc_d    = pc_inc;
        case (instr.uop)
          qefa_pkg::U_MUL, qefa_pkg::U_MODIN: begin
            state_d = qefa_pkg::ST_WAIT;
            pc_d    = pc_q;
          end
          qefa_pkg::U_BRZ:      if (status_i.e_zero) pc_d = instr.target;
          qefa_pkg::U_BRL0:     if (!status_i.e_lsb) pc_d = instr.target;
          qefa_pkg::U_JMP:      pc_d = instr.target;
          qefa_pkg::U_DISPATCH: pc_d = qefa_pkg::entry(status_i.op, status_i.mod_zero);
          qefa_pkg::U_DONE: begin
            pc_d = pc_q;
            // wait here until the output register can take the item
            if (status_i.out_free) state_d = qefa_pkg::ST_IDLE;
            else                   state_d = qefa_pkg::ST_EXEC;
          end
          default: ;
        endcase
      end
      qefa_pkg::ST_WAIT: begin
        if (status_i.unit_done) begin
          pc_d    = pc_inc;
          state_d = qefa_pkg::ST_FETCH;
        end
      end
      default: state_d = qefa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qefa_pkg::ST_IDLE;
      pc_q    <= qefa_pkg::A_PRO;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign in_stall_o = (state_q != qefa_pkg::ST_IDLE);

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.unit_done |-> state_q == qefa_pkg::ST_WAIT)
    else $error("arithmetic unit finished outside of wait state");

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < qefa_pkg::UCODE_LEN)
    else $error("program counter left the microprogram");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qefa_pkg::ST_EXEC && instr.uop == qefa_pkg::U_DONE && status_i.out_free)
    |=> state_q == qefa_pkg::ST_IDLE)
    else $error("item result issued but sequencer did not go idle");

endmodule

[design/qefa_dp.sv]
// Datapath: config registers, register file, modular add/sub, Barrett and remainder units.
module qefa_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [63:0]            cfg_wdata_i,
  input  qefa_pkg::in_item_t     in_data_i,
  output qefa_pkg::out_item_t    out_data_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  qefa_pkg::ctl_cmd_t     cmd_i,
  output qefa_pkg::dp_status_t   status_o
);

  localparam int FW = qefa_pkg::FW;

  logic [FW-1:0]              mod_q;
  logic [5:0]                 bits_q;
  logic [qefa_pkg::EW-1:0]    recip_q;
  qefa_pkg::in_item_t         in_q;
  logic [qefa_pkg::EW-1:0]    e_q;
  logic [FW-1:0]              rf_q [16];
  logic [FW-1:0]              rd_a_q, rd_b_q;
  qefa_pkg::out_item_t        out_q;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free, load_out;
  logic                       we;
  logic [qefa_pkg::RF_AW-1:0] waddr;
  logic [FW-1:0]              wdata;
  logic                       bar_done, modu_start, modu_done;
  logic [63:0]                bar_res, modu_val;
  logic [FW-1:0]              modu_rem, in_field;

  function automatic logic [FW-1:0] madd(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                         input logic [FW-1:0] p);
    logic [FW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[FW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= FW'(3);
      bits_q  <= 6'd2;
      recip_q <= 64'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qefa_pkg::CFG_MODULUS: mod_q   <= cfg_wdata_i[FW-1:0];
        qefa_pkg::CFG_BITS:    bits_q  <= cfg_wdata_i[5:0];
        qefa_pkg::CFG_RECIP:   recip_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
    if (cmd_i.exec) begin
      case (cmd_i.uop)
        qefa_pkg::U_ELOADI: e_q <= in_q.exponent;
        qefa_pkg::U_ELOADP: e_q <= {{(qefa_pkg::EW-FW){1'b0}}, mod_q} - 64'd2;
        qefa_pkg::U_ESHIFT: e_q <= {1'b0, e_q[qefa_pkg::EW-1:1]};
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.ra)
      qefa_pkg::R_ARE: in_field = in_q.a_re;
      qefa_pkg::R_AIM: in_field = in_q.a_im;
      qefa_pkg::R_BRE: in_field = in_q.b_re;
      default:         in_field = in_q.b_im;
    endcase
  end

  // remainder unit serves both operand reduction and the end of each product
  assign modu_start = (cmd_i.exec && cmd_i.uop == qefa_pkg::U_MODIN) || bar_done;
  assign modu_val   = bar_done ? bar_res : {{(64-FW){1'b0}}, in_field};

  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.dst;
    wdata = modu_rem;
    if (modu_done) begin
      we = 1'b1;
    end else if (cmd_i.exec) begin
      case (cmd_i.uop)
        qefa_pkg::U_ADD: begin
          we    = 1'b1;
          wdata = madd(rd_a_q, rd_b_q, mod_q);
        end
        qefa_pkg::U_SUB: begin
          we    = 1'b1;
          wdata = madd(rd_a_q, mod_q - rd_b_q, mod_q);
        end
        qefa_pkg::U_CONST0: begin
          we    = 1'b1;
          wdata = '0;
        end
        qefa_pkg::U_CONST1: begin
          we    = 1'b1;
          wdata = (mod_q == FW'(1)) ? '0 : FW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) rf_q[waddr] <= wdata;
    rd_a_q <= rf_q[cmd_i.ra];
    rd_b_q <= rf_q[cmd_i.rb];
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = cmd_i.exec && (cmd_i.uop == qefa_pkg::U_DONE) && out_free;
  assign out_valid_d = load_out ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.r_re <= rd_a_q;
      out_q.r_im <= rd_b_q;
    end
  end

  qefa_barrett u_bar (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.exec && cmd_i.uop == qefa_pkg::U_MUL),
    .x_i    (rd_a_q),
    .y_i    (rd_b_q),
    .mod_i  (mod_q),
    .bits_i (bits_q),
    .recip_i(recip_q),
    .done_o (bar_done),
    .res_o  (bar_res)
  );

  qefa_modu u_modu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(modu_start),
    .val_i  (modu_val),
    .mod_i  (mod_q),
    .done_o (modu_done),
    .rem_o  (modu_rem)
  );

  assign status_o.unit_done = modu_done;
  assign status_o.e_zero    = (e_q == '0);
  assign status_o.e_lsb     = e_q[0];
  assign status_o.out_free  = out_free;
  assign status_o.mod_zero  = (mod_q == '0);
  assign status_o.op        = in_q.operation;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the F_p[i] ALU core: random and directed items with a scoreboard predictor.
`timescale 1ns / 100ps

class ext_result_board;
  logic [63:0]         fmod;
  logic [63:0]         flen;
  logic [63:0]         frecip;
  qefa_pkg::out_item_t awaited[$];
  int                  mismatches;

  function new();
    fmod = 64'd3;
    flen = 64'd2;
    frecip = 64'd6;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      qefa_pkg::CFG_MODULUS: fmod = {2'b00, val[61:0]};
      qefa_pkg::CFG_BITS:    flen = {58'd0, val[5:0]};
      qefa_pkg::CFG_RECIP:   frecip = val;
      default: ;
    endcase
  endfunction

  // Barrett product, exact to the hardware's truncations
  function logic [63:0] bmul(logic [63:0] x, logic [63:0] y);
    logic [127:0] p;
    logic [63:0]  mask, hs, ls, q, r0, r1;
    int unsigned  len;
    len = {26'd0, flen[5:0]};
    if (len == 0) len = 1;
    mask = (64'd1 << len) - 64'd1;
    p = {64'd0, x} * {64'd0, y};
    hs = 64'(p >> len);
    ls = p[63:0] & mask;
    p = {64'd0, hs} * {64'd0, frecip};
    q = 64'(p >> len);
    p = {64'd0, q} * {64'd0, fmod};
    r0 = p[63:0] & mask;
    r1 = 64'(p >> len);
    r0 = ls - r0;
    r1 = (hs - r1) - ((ls < r0) ? 64'd1 : 64'd0);
    r0 = (r0 - r1 * fmod) & mask;
    return r0 % fmod;
  endfunction

  function logic [63:0] madd(logic [63:0] x, logic [63:0] y);
    logic [63:0] s;
    s = x + y;
    if (s >= fmod) s = s - fmod;
    return s;
  endfunction

  function logic [63:0] msub(logic [63:0] x, logic [63:0] y);
    return madd(x, fmod - y);
  endfunction

  function void ext_mul(input logic [63:0] xr, xi, yr, yi,
                        output logic [63:0] rr, ri);
    logic [63:0] all, ac, bd, bd3;
    all = bmul(madd(xr, xi), madd(yr, yi));
    ac = bmul(xr, yr);
    bd = bmul(xi, yi);
    bd3 = madd(madd(bd, bd), bd);
    rr = msub(ac, bd3);
    ri = msub(msub(all, ac), bd);
  endfunction

  function qefa_pkg::out_item_t predict(qefa_pkg::in_item_t it);
    qefa_pkg::out_item_t r;
    logic [63:0] ar, ai, br, bi, rr, ri, s, ni, t1, nrm, e, acc, xr, xi;
    rr = 64'd0;
    ri = 64'd0;
    if (fmod != 64'd0) begin
      ar = {2'b00, it.a_re} % fmod;
      ai = {2'b00, it.a_im} % fmod;
      br = {2'b00, it.b_re} % fmod;
      bi = {2'b00, it.b_im} % fmod;
      case (it.operation)
        qefa_pkg::OP_ADD: begin
          rr = madd(ar, br);
          ri = madd(ai, bi);
        end
        qefa_pkg::OP_SUB: begin
          rr = msub(ar, br);
          ri = msub(ai, bi);
        end
        qefa_pkg::OP_MUL: ext_mul(ar, ai, br, bi, rr, ri);
        qefa_pkg::OP_NEG: begin
          rr = msub(64'd0, ar);
          ri = msub(64'd0, ai);
        end
        qefa_pkg::OP_MULW: begin
          s = msub(64'd0, madd(ar, ai));
          ni = msub(64'd0, ai);
          rr = madd(madd(s, s), s);
          ri = madd(ar, madd(madd(ni, ni), ni));
        end
        qefa_pkg::OP_INV: begin
          t1 = bmul(ai, ai);
          nrm = madd(bmul(ar, ar), madd(madd(t1, t1), t1));
          e = fmod - 64'd2;
          acc = 64'd1 % fmod;
          while (e != 64'd0) begin
            if (e[0]) acc = bmul(acc, nrm);
            nrm = bmul(nrm, nrm);
            e = e >> 1;
          end
          rr = bmul(ar, acc);
          ri = msub(64'd0, bmul(ai, acc));
        end
        qefa_pkg::OP_POW: begin
          rr = 64'd1 % fmod;
          ri = 64'd0;
          xr = ar;
          xi = ai;
          e = it.exponent;
          while (e != 64'd0) begin
            if (e[0]) ext_mul(rr, ri, xr, xi, rr, ri);
            ext_mul(xr, xi, xr, xi, xr, xi);
            e = e >> 1;
          end
        end
        default: ;
      endcase
    end
    r.r_re = rr[61:0];
    r.r_im = ri[61:0];
    return r;
  endfunction

  function void note_operands(qefa_pkg::in_item_t it);
    awaited.push_back(predict(it));
  endfunction

  function void check_result(qefa_pkg::out_item_t got);
    qefa_pkg::out_item_t want;
    if (awaited.size() == 0) begin
      $error("result item with none outstanding: re=%h im=%h", got.r_re, got.r_im);
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    if (got.r_re !== want.r_re) begin
      $error("r_re expected %h actual %h", want.r_re, got.r_re);
      mismatches++;
    end
    if (got.r_im !== want.r_im) begin
      $error("r_im expected %h actual %h", want.r_im, got.r_im);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return awaited.size();
  endfunction
endclass

module tb_top;
  localparam logic [2:0]  OP_UNUSED = 3'd7;
  localparam logic [61:0] ALL1      = {62{1'b1}};
  localparam logic [63:0] P62       = 64'h3FFF_FFFF_FFFF_FFC7;  // 2^62 - 57
  localparam logic [63:0] P61       = 64'h1FFF_FFFF_FFFF_FFFF;  // 2^61 - 1
  localparam int          WDOG_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 3000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  qefa_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  qefa_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_idx = qefa_pkg::CFG_MODULUS;
  logic [63:0]         cfg_wdata = 64'd0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int idle_cycles = 0;
  ext_result_board board;

  quadratic_extension_field_alu_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // receiver: random stall bursts, one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] recip_for(logic [63:0] p, int unsigned b);
    logic [127:0] num;
    num = 128'd1 << (2 * b);
    return 64'd1 + 64'(num / {64'd0, p});
  endfunction

  // leaves the write enable high; set_field lowers it after the last write
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_field(logic [63:0] p, logic [63:0] b, logic [63:0] rcp);
    write_reg(qefa_pkg::CFG_MODULUS, p);
    write_reg(qefa_pkg::CFG_BITS, b);
    write_reg(qefa_pkg::CFG_RECIP, rcp);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(qefa_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    board.note_operands(it);
  endtask

  task automatic send_op(logic [2:0] op, logic [61:0] ar, logic [61:0] ai,
                         logic [61:0] br, logic [61:0] bi, logic [63:0] e);
    qefa_pkg::in_item_t it;
    it.operation = op;
    it.a_re = ar;
    it.a_im = ai;
    it.b_re = br;
    it.b_im = bi;
    it.exponent = e;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [61:0] pick_operand(logic [63:0] p);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1:    return raw[61:0];
      2, 3:    return (p != 0) ? 62'(raw % p) : raw[61:0];
      4:       return 62'd0;
      default: return ($urandom_range(0, 1) && p != 0) ? 62'(p - 1) : ALL1;
    endcase
  endfunction

  task automatic random_items(int n, int hold_at);
    logic [2:0]  op;
    logic [63:0] e;
    int          k;
    logic        cheap_inv;
    cheap_inv = (board.flen[5:0] <= 24);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      k = $urandom_range(0, 31);
      if (k <= 5) op = qefa_pkg::OP_ADD;
      else if (k <= 11) op = qefa_pkg::OP_SUB;
      else if (k <= 16) op = qefa_pkg::OP_MUL;
      else if (k <= 20) op = qefa_pkg::OP_NEG;
      else if (k <= 24) op = qefa_pkg::OP_MULW;
      else if (k == 25) op = OP_UNUSED;
      else if (k == 26 || (k == 27 && cheap_inv)) op = qefa_pkg::OP_INV;
      else op = qefa_pkg::OP_POW;
      // exponent cost grows with its bit length: keep most short
      if ($urandom_range(0, 9) == 0) e = 64'($urandom_range(0, 4095));
      else e = 64'($urandom_range(0, 15));
      send_op(op, pick_operand(board.fmod), pick_operand(board.fmod),
              pick_operand(board.fmod), pick_operand(board.fmod), e);
    end
  endtask

  initial begin
    logic [61:0] pm1;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    random_items(180, -1);  // reset values of the field registers
    drain();

    set_field(P62, 64'd62, recip_for(P62, 62));
    pm1 = 62'(P62 - 1);
    send_op(qefa_pkg::OP_ADD, ALL1, ALL1, ALL1, ALL1, 64'd0);
    send_op(qefa_pkg::OP_ADD, pm1, pm1, pm1, pm1, 64'd0);
    send_op(qefa_pkg::OP_SUB, 62'd0, 62'd0, ALL1, ALL1, 64'd0);
    send_op(qefa_pkg::OP_SUB, 62'd0, pm1, pm1, 62'd0, 64'd0);
    send_op(qefa_pkg::OP_MUL, ALL1, ALL1, ALL1, ALL1, 64'd0);
    send_op(qefa_pkg::OP_MUL, pm1, pm1, pm1, pm1, 64'd0);
    send_op(qefa_pkg::OP_MUL, 62'd0, 62'd1, 62'd0, 62'd1, 64'd0);  // i*i
    send_op(qefa_pkg::OP_NEG, 62'd0, 62'd0, 62'd0, 62'd0, 64'd0);
    send_op(qefa_pkg::OP_NEG, pm1, ALL1, 62'd0, 62'd0, 64'd0);
    send_op(qefa_pkg::OP_MULW, ALL1, ALL1, 62'd0, 62'd0, 64'd0);
    send_op(qefa_pkg::OP_MULW, 62'd0, 62'd0, 62'd0, 62'd0, 64'd0);
    send_op(OP_UNUSED, ALL1, ALL1, ALL1, ALL1, {64{1'b1}});
    send_op(qefa_pkg::OP_INV, 62'd0, 62'd0, ALL1, ALL1, 64'd0);  // zero maps to zero
    send_op(qefa_pkg::OP_INV, pm1, ALL1, 62'd0, 62'd0, 64'd0);
    send_op(qefa_pkg::OP_POW, ALL1, pm1, 62'd0, 62'd0, 64'd0);   // zero exponent gives one
    send_op(qefa_pkg::OP_POW, 62'd5, 62'd7, ALL1, ALL1, {64{1'b1}});
    send_op(qefa_pkg::OP_POW, pm1, 62'd3, 62'd0, 62'd0, 64'h8000_0000_0000_0000);
    send_op(qefa_pkg::OP_POW, 62'd0, 62'd0, 62'd0, 62'd0, 64'd5);
    drain();

    set_field(64'd7, 64'd3, recip_for(64'd7, 3));
    random_items(150, 30);  // long receiver hold-off fills the block
    drain();
    set_field(64'd7, 64'd0, recip_for(64'd7, 1));  // zero bit length acts as one
    random_items(60, -1);
    drain();
    set_field(64'd65537, 64'd17, recip_for(64'd65537, 17));
    random_items(150, -1);
    drain();
    set_field(64'd1000003, 64'd20, recip_for(64'd1000003, 20));
    random_items(150, -1);
    drain();
    set_field(P61, 64'd61, recip_for(P61, 61));
    random_items(120, -1);
    drain();
    set_field(P62, 64'd62, recip_for(P62, 62));
    random_items(120, -1);
    drain();
    set_field(64'd0, 64'd62, 64'd0);  // zero modulus
    random_items(60, -1);
    drain();
    // inconsistent Barrett registers
    set_field(P62, 64'($urandom_range(0, 63)), {$urandom, $urandom});
    random_items(40, -1);
    drain();
    set_field(64'd1000003, 64'd63, {64{1'b1}});
    random_items(40, -1);
    drain();
    calm = 1'b1;
    // upper write bits beyond the modulus width are dropped
    set_field({2'b11, ALL1}, 64'hFFFF_FFFF_FFFF_FFFE, recip_for({2'b00, ALL1}, 62));
    random_items(60, -1);
    drain();
    repeat (100) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
